@@ hw/rtl/sha1_hash_engine_unit_macros.svh @@
// Assertion helpers shared by the hash engine RTL.
`ifndef SHA1_HASH_ENGINE_UNIT_MACROS_SVH
`define SHA1_HASH_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SHA1HEU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SHA1HEU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/sha1heu_pkg.sv @@
package sha1heu_pkg;

  localparam int unsigned DigestWords = 5;
  localparam int unsigned BlockWords  = 16;
  localparam int unsigned Rounds      = 80;

  typedef logic [DigestWords-1:0][31:0] sha1heu_hv_t;

  // Index 0 holds h0.
  localparam sha1heu_hv_t InitChain = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PadMark = 8'h80;

  localparam logic [6:0] LastRound  = 7'd79;
  localparam logic [5:0] LastByte   = 6'd63;
  localparam logic [5:0] LengthPos  = 6'd56;
  localparam logic [2:0] LastDigest = 3'd4;

  typedef struct packed {
    logic       load;
    logic [7:0] data;
    logic       step;
  } sha1heu_sched_ctl_t;

  typedef struct packed {
    logic init;
    logic step;
    logic fold;
    logic restart;
  } sha1heu_rnd_ctl_t;

endpackage

@@ hw/rtl/sha1heu_sched.sv @@
// Block buffer and rolling message schedule: one 512-bit shift line.
// words_q[15] is always the schedule word of the current round.
module sha1heu_sched
  import sha1heu_pkg::*;
(
  input  logic               clk_i,
  input  sha1heu_sched_ctl_t ctl_i,
  output logic [31:0]        w_o
);

  logic [BlockWords-1:0][31:0] words_q, words_d;
  logic [31:0]                 mix;

  assign mix = words_q[2] ^ words_q[7] ^ words_q[13] ^ words_q[15];

  always_comb begin
    words_d = words_q;
    if (ctl_i.load) begin
      // shift the whole line up one byte, new byte at the bottom
      words_d = {words_q[BlockWords-1][23:0], words_q[BlockWords-2:0], ctl_i.data};
    end else if (ctl_i.step) begin
      words_d = {words_q[BlockWords-2:0], {mix[30:0], mix[31]}};
    end
  end

  always_ff @(posedge clk_i) begin
    words_q <= words_d;
  end

  assign w_o = words_q[BlockWords-1];

endmodule

@@ hw/rtl/sha1heu_round.sv @@
// Shared round unit: work variables a..e, one round per cycle, and chaining values.
module sha1heu_round
  import sha1heu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sha1heu_rnd_ctl_t ctl_i,
  input  logic [6:0]       round_i,
  input  logic [31:0]      w_i,
  output sha1heu_hv_t      chain_o
);

  sha1heu_hv_t chain_q, chain_d;
  sha1heu_hv_t vars_q, vars_d;
  logic [31:0] a, b, c, d, e;
  logic [31:0] f, k, tmp;

  assign a = vars_q[0];
  assign b = vars_q[1];
  assign c = vars_q[2];
  assign d = vars_q[3];
  assign e = vars_q[4];

  always_comb begin
    priority if (round_i < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (round_i < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (round_i < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  assign tmp = {a[26:0], a[31:27]} + f + e + k + w_i;

  always_comb begin
    vars_d  = vars_q;
    chain_d = chain_q;
    if (ctl_i.init) begin
      vars_d = chain_q;
    end else if (ctl_i.step) begin
      vars_d = {d, c, {b[1:0], b[31:2]}, a, tmp};
    end
    if (ctl_i.fold) begin
      for (int i = 0; i < DigestWords; i++) begin
        chain_d[i] = chain_q[i] + vars_q[i];
      end
    end else if (ctl_i.restart) begin
      chain_d = InitChain;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= InitChain;
      vars_q  <= '0;
    end else begin
      chain_q <= chain_d;
      vars_q  <= vars_d;
    end
  end

  assign chain_o = chain_q;

endmodule

@@ hw/rtl/sha1_hash_engine_unit.sv @@
// SHA-1 engine taking one message byte per input transaction. A byte that does not
// fill a block is taken without a stall. The byte that completes a 64-byte block
// starts a compression: 80 rounds through one shared round unit, one round a cycle,
// then a fold step that adds the result into the chaining values; the input stalls
// until the fold is done. On end_of_message (after compressing the block its byte
// completes, if it does) the rest of the block is filled with padding bytes, one per
// cycle, and compressed; when fewer than 9 bytes were left for the 0x80 mark and the
// length, a second block of 64 padding bytes and a second compression follow. The
// five digest words then leave h0 first, one per cycle while the output side takes
// them; the engine then reloads the initial values and accepts the next message.
`include "sha1_hash_engine_unit_macros.svh"

module sha1_hash_engine_unit
  import sha1heu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
  input  logic        s_axis_tuser,   // [0] byte_present
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        m_axis_tlast    // last_word
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_COMP,
    S_FOLD,
    S_OUT
  } state_e;

  state_e             state_q, state_d;
  logic [5:0]         pos_q, pos_d;
  logic [63:0]        cnt_q, cnt_d;
  logic [6:0]         round_q, round_d;
  logic               pad_q, pad_d;
  logic               final_q, final_d;
  logic               mark_q, mark_d;
  logic               lenblk_q, lenblk_d;
  logic [2:0]         oidx_q, oidx_d;
  logic               ovalid_q, ovalid_d;
  logic [31:0]        oword_q, oword_d;
  logic [2:0]         onum_q, onum_d;
  logic               olast_q, olast_d;

  sha1heu_sched_ctl_t sched_ctl;
  sha1heu_rnd_ctl_t   rnd_ctl;
  logic [31:0]        w;
  sha1heu_hv_t        chain;
  logic               in_acc;
  logic               out_free;
  logic [7:0]         len_byte;
  logic [31:0]        chain_sel;

  sha1heu_sched u_sched (
    .clk_i (clk_i),
    .ctl_i (sched_ctl),
    .w_o   (w)
  );

  sha1heu_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (rnd_ctl),
    .round_i (round_q),
    .w_i     (w),
    .chain_o (chain)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !ovalid_q || m_axis_tready;

  // Length bytes go out most significant first at positions 56..63.
  always_comb begin
    unique case (pos_q[2:0])
      3'd0:    len_byte = cnt_q[63:56];
      3'd1:    len_byte = cnt_q[55:48];
      3'd2:    len_byte = cnt_q[47:40];
      3'd3:    len_byte = cnt_q[39:32];
      3'd4:    len_byte = cnt_q[31:24];
      3'd5:    len_byte = cnt_q[23:16];
      3'd6:    len_byte = cnt_q[15:8];
      default: len_byte = cnt_q[7:0];
    endcase
  end

  always_comb begin
    unique case (oidx_q)
      3'd0:    chain_sel = chain[0];
      3'd1:    chain_sel = chain[1];
      3'd2:    chain_sel = chain[2];
      3'd3:    chain_sel = chain[3];
      3'd4:    chain_sel = chain[4];
      default: chain_sel = chain[0];
    endcase
  end

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    round_d   = round_q;
    pad_d     = pad_q;
    final_d   = final_q;
    mark_d    = mark_q;
    lenblk_d  = lenblk_q;
    oidx_d    = oidx_q;
    ovalid_d  = ovalid_q && !m_axis_tready;
    oword_d   = oword_q;
    onum_d    = onum_q;
    olast_d   = olast_q;
    sched_ctl = '0;
    rnd_ctl   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          mark_d   = 1'b0;
          lenblk_d = 1'b0;
          pad_d    = s_axis_tlast;
          final_d  = 1'b0;
          if (s_axis_tuser) begin
            sched_ctl.load = 1'b1;
            sched_ctl.data = s_axis_tdata;
            cnt_d          = cnt_q + 64'd8;
            pos_d          = pos_q + 6'd1;
          end
          if (s_axis_tuser && pos_q == LastByte) begin
            rnd_ctl.init = 1'b1;
            round_d      = '0;
            state_d      = S_COMP;
          end else if (s_axis_tlast) begin
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        sched_ctl.load = 1'b1;
        if (!mark_q) begin
          sched_ctl.data = PadMark;
          mark_d         = 1'b1;
          lenblk_d       = (pos_q < LengthPos);
        end else if (lenblk_q && pos_q >= LengthPos) begin
          sched_ctl.data = len_byte;
        end else begin
          sched_ctl.data = '0;
        end
        pos_d = pos_q + 6'd1;
        if (pos_q == LastByte) begin
          rnd_ctl.init = 1'b1;
          round_d      = '0;
          final_d      = mark_q && lenblk_q;
          state_d      = S_COMP;
        end
      end
      S_COMP: begin
        rnd_ctl.step   = 1'b1;
        sched_ctl.step = 1'b1;
        round_d        = round_q + 7'd1;
        if (round_q == LastRound) begin
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        rnd_ctl.fold = 1'b1;
        priority if (final_q) begin
          oidx_d  = '0;
          state_d = S_OUT;
        end else if (pad_q) begin
          // a spilled mark leaves the length for the next block
          if (mark_q) begin
            lenblk_d = 1'b1;
          end
          state_d = S_PAD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          oword_d  = chain_sel;
          onum_d   = oidx_q;
          olast_d  = (oidx_q == LastDigest);
          oidx_d   = oidx_q + 3'd1;
          if (oidx_q == LastDigest) begin
            rnd_ctl.restart = 1'b1;
            pos_d           = '0;
            cnt_d           = '0;
            pad_d           = 1'b0;
            final_d         = 1'b0;
            state_d         = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pos_q    <= '0;
      cnt_q    <= '0;
      round_q  <= '0;
      pad_q    <= 1'b0;
      final_q  <= 1'b0;
      mark_q   <= 1'b0;
      lenblk_q <= 1'b0;
      oidx_q   <= '0;
      ovalid_q <= 1'b0;
      oword_q  <= '0;
      onum_q   <= '0;
      olast_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      cnt_q    <= cnt_d;
      round_q  <= round_d;
      pad_q    <= pad_d;
      final_q  <= final_d;
      mark_q   <= mark_d;
      lenblk_q <= lenblk_d;
      oidx_q   <= oidx_d;
      ovalid_q <= ovalid_d;
      oword_q  <= oword_d;
      onum_q   <= onum_d;
      olast_q  <= olast_d;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {5'd0, onum_q, oword_q};
  assign m_axis_tlast  = olast_q;

  `SHA1HEU_ASSERT_IMP(a_last_is_h4, m_axis_tvalid && m_axis_tlast,
                      m_axis_tdata[34:32] == LastDigest, "last digest word not h4")
  `SHA1HEU_ASSERT_IMP(a_round_range, state_q == S_COMP, round_q <= LastRound,
                      "round counter past last round")
  `SHA1HEU_ASSERT_NXT(a_block_full, in_acc && s_axis_tuser && pos_q == LastByte,
                      state_q == S_COMP, "full block did not start compression")
  `SHA1HEU_ASSERT_IMP(a_out_only_final, state_q == S_OUT, final_q || oidx_q != 3'd0,
                      "digest output without final block")

endmodule

@@ dv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sha1heu_pkg::*;

  typedef logic [0:4][31:0] digest_t;  // h0 first

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       eom;
    logic       known;
    digest_t    dig;
  } msg_row_t;

  localparam digest_t EmptyDigest =
    {32'hDA39A3EE, 32'h5E6B4B0D, 32'h3255BFEF, 32'h95601890, 32'hAFD80709};
  localparam digest_t AbcDigest =
    {32'hA9993E36, 32'h4706816A, 32'hBA3E2571, 32'h7850C26C, 32'h9CD0D89D};

  localparam int DirRows = 16;
  localparam msg_row_t DirTab [DirRows] = '{
    '{8'hA5, 1'b0, 1'b1, 1'b1, EmptyDigest},  // empty message right after reset
    '{8'h61, 1'b1, 1'b0, 1'b0, '0},
    '{8'h62, 1'b1, 1'b0, 1'b0, '0},
    '{8'h63, 1'b1, 1'b1, 1'b1, AbcDigest},    // last byte carries the end
    '{8'hFF, 1'b0, 1'b0, 1'b0, '0},           // no byte, no end
    '{8'h61, 1'b1, 1'b0, 1'b0, '0},
    '{8'h62, 1'b1, 1'b0, 1'b0, '0},
    '{8'h63, 1'b1, 1'b0, 1'b0, '0},
    '{8'h5A, 1'b0, 1'b1, 1'b1, AbcDigest},    // end without a byte
    '{8'h00, 1'b0, 1'b1, 1'b1, EmptyDigest},  // empty message right after a digest
    '{8'hFF, 1'b1, 1'b1, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, 1'b0, '0},
    '{8'h3C, 1'b0, 1'b0, 1'b0, '0},
    '{8'h80, 1'b1, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b1, 1'b0, '0},
    '{8'h7F, 1'b1, 1'b1, 1'b0, '0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] msg_byte
  logic        s_axis_tuser;   // [0] byte_present
  logic        s_axis_tlast;   // end_of_message
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [31:0] digest_word, [34:32] word_index, rest zero
  logic        m_axis_tlast;   // last_word

  sha1_hash_engine_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Predictor state
  sha1heu_hv_t chain_h;
  logic [31:0] blk_w [16];
  logic [5:0]  blk_pos;
  logic [63:0] msg_bits;

  digest_word_t digest_q [$];
  int unsigned  err_cnt;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    send_idle_pct = 24;
    recv_idle_pct = 80;
    err_cnt       = 0;
  end

  always #10 clk_i = ~clk_i;

  function automatic void put_blk_byte(input logic [5:0] p, input logic [7:0] v);
    logic [31:0] v32;
    v32 = {24'h0, v} << ((3 - p[1:0]) * 8);
    if (p[1:0] == 2'd0) begin
      blk_w[p[5:2]] = v32;
    end else begin
      blk_w[p[5:2]] = blk_w[p[5:2]] | v32;
    end
  endfunction

  function automatic void sha1_compress();
    logic [31:0] a, b, c, d, e, w, f, k, tmp;
    logic [3:0]  s;
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int t = 0; t < 80; t++) begin
      s = t[3:0];
      // roll the schedule in place from round 16 on
      if (t >= 16) begin
        w = blk_w[s + 4'd13] ^ blk_w[s + 4'd8] ^ blk_w[s + 4'd2] ^ blk_w[s];
        blk_w[s] = {w[30:0], w[31]};
      end
      w = blk_w[s];
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      tmp = {a[26:0], a[31:27]} + f + e + k + w;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = tmp;
    end
    chain_h[0] = chain_h[0] + a;
    chain_h[1] = chain_h[1] + b;
    chain_h[2] = chain_h[2] + c;
    chain_h[3] = chain_h[3] + d;
    chain_h[4] = chain_h[4] + e;
  endfunction

  // Absorb one transaction; return 1 with the digest when the message closes.
  function automatic bit sha1_absorb(input logic [7:0] data, input logic present,
                                     input logic eom, output digest_t dig);
    int pos;
    dig = '0;
    if (present) begin
      put_blk_byte(blk_pos, data);
      msg_bits = msg_bits + 64'd8;
      blk_pos  = blk_pos + 6'd1;
      if (blk_pos == 6'd0) sha1_compress();
    end
    if (!eom) return 1'b0;
    pos = blk_pos;
    put_blk_byte(pos[5:0], PadMark);
    pos++;
    // length does not fit: close this block and put it in a fresh one
    if (pos > 56) begin
      for (; pos < 64; pos++) put_blk_byte(pos[5:0], 8'h00);
      sha1_compress();
      pos = 0;
    end
    for (; pos < 56; pos++) put_blk_byte(pos[5:0], 8'h00);
    blk_w[14] = msg_bits[63:32];
    blk_w[15] = msg_bits[31:0];
    sha1_compress();
    for (int i = 0; i < 5; i++) dig[i] = chain_h[i];
    chain_h  = InitChain;
    blk_pos  = '0;
    msg_bits = '0;
    return 1'b1;
  endfunction

  // Entered and left just after a falling edge.
  task automatic send_item(input logic [7:0] data, input logic present, input logic eom,
                           input logic known, input digest_t kdig);
    digest_t      dig;
    bit           done;
    digest_word_t exp_item;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= present;
    s_axis_tlast  <= eom;
    do @(posedge clk_i); while (!s_axis_tready);
    done = sha1_absorb(data, present, eom, dig);
    if (done) begin
      if (known) dig = kdig;
      for (int i = 0; i < 5; i++) begin
        exp_item = '{word: dig[i], idx: i[2:0], last: (i == 4)};
        digest_q = {digest_q, exp_item};
      end
    end
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    digest_word_t exp_w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (digest_q.size() == 0) begin
        $error("unexpected digest word: data %h last %b", m_axis_tdata, m_axis_tlast);
        err_cnt++;
      end else begin
        exp_w = digest_q.pop_front();
        if (m_axis_tdata[31:0] !== exp_w.word) begin
          $error("digest_word: expected %h actual %h", exp_w.word, m_axis_tdata[31:0]);
          err_cnt++;
        end
        if (m_axis_tdata[34:32] !== exp_w.idx) begin
          $error("word_index: expected %0d actual %0d", exp_w.idx, m_axis_tdata[34:32]);
          err_cnt++;
        end
        if (m_axis_tlast !== exp_w.last) begin
          $error("last_word: expected %b actual %b", exp_w.last, m_axis_tlast);
          err_cnt++;
        end
        if (m_axis_tdata[39:35] !== 5'd0) begin
          $error("tdata pad: expected %h actual %h", 5'd0, m_axis_tdata[39:35]);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int unsigned n_items;
    int unsigned n_msgs;
    int unsigned len;
    bit          tail_byte;
    logic        eom;
    chain_h  = InitChain;
    blk_pos  = '0;
    msg_bits = '0;
    for (int i = 0; i < 16; i++) blk_w[i] = '0;
    n_items = DirRows;
    n_msgs  = 0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < DirRows; r++) begin
      send_item(DirTab[r].data, DirTab[r].present, DirTab[r].eom,
                DirTab[r].known, DirTab[r].dig);
    end

    while (n_msgs < 2 || n_items < 110) begin
      if (n_msgs == 0) begin
        send_idle_pct = 80;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // first message: a full block, then a tail that leaves no room for the length; later ones 0..12 bytes
      if (n_msgs == 0) begin
        len = 120;
      end else begin
        len = $urandom_range(0, 12);
      end
      tail_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int unsigned i = 0; i < len; i++) begin
        if ($urandom_range(0, 15) == 0) begin
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
          n_items++;
        end
        eom = tail_byte && (i == len - 1);
        send_item(8'($urandom_range(0, 255)), 1'b1, eom, 1'b0, '0);
        n_items++;
      end
      if (!tail_byte) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
        n_items++;
      end
      n_msgs++;
    end
    s_axis_tvalid <= 1'b0;

    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/sha1heu_pkg.sv
hw/rtl/sha1heu_sched.sv
hw/rtl/sha1heu_round.sv
hw/rtl/sha1_hash_engine_unit.sv
dv/tb_top.sv
